FILE: src/pfig_pkg.sv
package pfig_pkg;

  localparam int VERTEX_CAPACITY_DEF = 64;
  localparam int MAX_TRIANGLES       = 62;

  localparam int COUNT_W   = 8;
  localparam int CORNER_W  = 6;
  localparam int POLYS_W   = 5;
  localparam int VERTS_W   = 7;
  localparam int INDICES_W = 8;
  localparam int TRIS_W    = 6;

  localparam logic ACT_POLYGON = 1'b0;
  localparam logic ACT_END     = 1'b1;

  typedef enum logic [1:0] {
    KIND_TRIANGLE = 2'd0,
    KIND_SKIPPED  = 2'd1,
    KIND_FULL     = 2'd2,
    KIND_SUMMARY  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_FAN
  } state_e;

  typedef struct packed {
    logic start;
    logic advance;
  } fan_ctrl_t;

endpackage

FILE: src/pfig_fan_unit.sv
module pfig_fan_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pfig_pkg::fan_ctrl_t             ctrl_i,
  input  logic [pfig_pkg::CORNER_W-1:0]   first_i,
  input  logic [pfig_pkg::TRIS_W-1:0]     tris_i,
  output logic [pfig_pkg::CORNER_W-1:0]   corner_a_o,
  output logic [pfig_pkg::CORNER_W-1:0]   corner_b_o,
  output logic [pfig_pkg::CORNER_W-1:0]   corner_c_o,
  output logic                            last_o
);

  logic [pfig_pkg::CORNER_W-1:0] a_q, b_q, c_q;
  logic [pfig_pkg::CORNER_W-1:0] b_d, c_d;
  logic [pfig_pkg::TRIS_W-1:0]   rem_q, rem_d;
  logic [pfig_pkg::CORNER_W-1:0] inc_src;
  logic [pfig_pkg::CORNER_W-1:0] inc_sum;

  assign inc_src = ctrl_i.start ? first_i : c_q;
  assign inc_sum = inc_src + pfig_pkg::CORNER_W'(1);

  always_comb begin
    b_d   = b_q;
    c_d   = c_q;
    rem_d = rem_q;
    if (ctrl_i.start) begin
      b_d   = inc_sum;
      c_d   = inc_sum + pfig_pkg::CORNER_W'(1);
      rem_d = tris_i;
    end else if (ctrl_i.advance) begin
      b_d   = c_q;
      c_d   = inc_sum;
      rem_d = rem_q - pfig_pkg::TRIS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      a_q <= first_i;
    end
    b_q <= b_d;
    c_q <= c_d;
  end

  assign corner_a_o = a_q;
  assign corner_b_o = b_q;
  assign corner_c_o = c_q;
  assign last_o     = (rem_q == pfig_pkg::TRIS_W'(1));

endmodule

FILE: src/polygon_fan_index_generator.sv
// Polygon fan to triangle list index generator. Send one request per polygon
// (action 0, vertex count) and close the batch with an end request (action 1),
// which returns a summary with the polygon, vertex and index counts and the
// indexed-list flag, then starts a new batch. A polygon that is accepted into
// the batch yields its fan as one triangle per cycle while the output is not
// stalled; a polygon with n vertices is accepted, decided, then yields n-2
// triangles, capped at 62. Skipped, dropped and end requests each give one
// result, and a polygon ignored after the batch is full gives no result. The
// input stalls from acceptance until the last result of the request is in the
// output register; a single output register lets a new request be taken while
// the previous result waits. VERTEX_CAPACITY sets the vertex limit per batch,
// and the polygon limit is a third of it.
module polygon_fan_index_generator #(
  parameter int VERTEX_CAPACITY = pfig_pkg::VERTEX_CAPACITY_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             action_i,
  input  logic [pfig_pkg::COUNT_W-1:0]     vertex_count_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       kind_o,
  output logic [pfig_pkg::CORNER_W-1:0]    corner_a_o,
  output logic [pfig_pkg::CORNER_W-1:0]    corner_b_o,
  output logic [pfig_pkg::CORNER_W-1:0]    corner_c_o,
  output logic [pfig_pkg::POLYS_W-1:0]     polygons_in_batch_o,
  output logic [pfig_pkg::VERTS_W-1:0]     vertices_in_batch_o,
  output logic [pfig_pkg::INDICES_W-1:0]   indices_in_batch_o,
  output logic                             use_indexed_o,
  output logic                             last_o
);

  localparam int CapW = $clog2(VERTEX_CAPACITY + 1);
  localparam int CmpW = (CapW > 9) ? CapW : 9;
  localparam logic [CmpW-1:0] CapVal  = CmpW'(VERTEX_CAPACITY);
  localparam logic [CmpW-1:0] PolyCap = CmpW'(VERTEX_CAPACITY / 3);

  pfig_pkg::state_e state_q, state_d;

  logic                                  act_q;
  logic [pfig_pkg::COUNT_W-1:0]          count_q;

  logic [pfig_pkg::VERTS_W-1:0]          next_vertex_q, next_vertex_d;
  logic [pfig_pkg::POLYS_W-1:0]          poly_tally_q, poly_tally_d;
  logic [pfig_pkg::INDICES_W-1:0]        index_tally_q, index_tally_d;
  logic                                  full_q, full_d;

  logic                                  out_valid_q;
  pfig_pkg::kind_e                       kind_q, kind_d;
  logic [pfig_pkg::CORNER_W-1:0]         a_q, a_d, b_q, b_d, c_q, c_d;
  logic [pfig_pkg::POLYS_W-1:0]          polys_q, polys_d;
  logic [pfig_pkg::VERTS_W-1:0]          verts_q, verts_d;
  logic [pfig_pkg::INDICES_W-1:0]        idx_q, idx_d;
  logic                                  indexed_q, indexed_d;
  logic                                  last_q, last_d;
  logic                                  load;

  logic                                  accept;
  logic                                  slot_free;
  logic                                  bad_count;
  logic                                  no_fit;
  logic [pfig_pkg::COUNT_W-1:0]          tris_raw;
  logic [pfig_pkg::TRIS_W-1:0]           tris;
  logic [pfig_pkg::INDICES_W-1:0]        tris_ext;

  pfig_pkg::fan_ctrl_t                   fan_ctrl;
  logic [pfig_pkg::CORNER_W-1:0]         fan_a, fan_b, fan_c;
  logic                                  fan_last;

  assign accept    = in_valid_i && (state_q == pfig_pkg::ST_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;

  assign bad_count = (count_q < pfig_pkg::COUNT_W'(3)) || (CmpW'(count_q) > CapVal);
  assign no_fit    = (CmpW'(poly_tally_q) >= PolyCap) ||
                     ((CmpW'(next_vertex_q) + CmpW'(count_q)) > CapVal);
  assign tris_raw  = count_q - pfig_pkg::COUNT_W'(2);
  assign tris      = (tris_raw > pfig_pkg::COUNT_W'(pfig_pkg::MAX_TRIANGLES)) ?
                     pfig_pkg::TRIS_W'(pfig_pkg::MAX_TRIANGLES) :
                     tris_raw[pfig_pkg::TRIS_W-1:0];
  assign tris_ext  = pfig_pkg::INDICES_W'(tris);

  pfig_fan_unit u_fan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (fan_ctrl),
    .first_i    (next_vertex_q[pfig_pkg::CORNER_W-1:0]),
    .tris_i     (tris),
    .corner_a_o (fan_a),
    .corner_b_o (fan_b),
    .corner_c_o (fan_c),
    .last_o     (fan_last)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      pfig_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = pfig_pkg::ST_DECIDE;
        end
      end
      pfig_pkg::ST_DECIDE: begin
        if (act_q == pfig_pkg::ACT_END) begin
          if (slot_free) state_d = pfig_pkg::ST_IDLE;
        end else if (full_q) begin
          state_d = pfig_pkg::ST_IDLE;
        end else if (bad_count || no_fit) begin
          if (slot_free) state_d = pfig_pkg::ST_IDLE;
        end else begin
          state_d = pfig_pkg::ST_FAN;
        end
      end
      pfig_pkg::ST_FAN: begin
        if (slot_free && fan_last) begin
          state_d = pfig_pkg::ST_IDLE;
        end
      end
      default: state_d = pfig_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    next_vertex_d    = next_vertex_q;
    poly_tally_d     = poly_tally_q;
    index_tally_d    = index_tally_q;
    full_d           = full_q;
    fan_ctrl.start   = 1'b0;
    fan_ctrl.advance = 1'b0;
    load             = 1'b0;
    kind_d           = pfig_pkg::KIND_TRIANGLE;
    a_d              = '0;
    b_d              = '0;
    c_d              = '0;
    polys_d          = '0;
    verts_d          = '0;
    idx_d            = '0;
    indexed_d        = 1'b0;
    last_d           = 1'b1;
    case (state_q)
      pfig_pkg::ST_DECIDE: begin
        if (act_q == pfig_pkg::ACT_END) begin
          if (slot_free) begin
            load          = 1'b1;
            kind_d        = pfig_pkg::KIND_SUMMARY;
            polys_d       = poly_tally_q;
            verts_d       = next_vertex_q;
            idx_d         = index_tally_q;
            indexed_d     = (poly_tally_q >= pfig_pkg::POLYS_W'(2));
            next_vertex_d = '0;
            poly_tally_d  = '0;
            index_tally_d = '0;
            full_d        = 1'b0;
          end
        end else if (full_q) begin
          load = 1'b0;
        end else if (bad_count) begin
          if (slot_free) begin
            load   = 1'b1;
            kind_d = pfig_pkg::KIND_SKIPPED;
          end
        end else if (no_fit) begin
          if (slot_free) begin
            load   = 1'b1;
            kind_d = pfig_pkg::KIND_FULL;
            full_d = 1'b1;
          end
        end else begin
          fan_ctrl.start = 1'b1;
          poly_tally_d   = poly_tally_q + pfig_pkg::POLYS_W'(1);
          next_vertex_d  = next_vertex_q + count_q[pfig_pkg::VERTS_W-1:0];
          index_tally_d  = index_tally_q + tris_ext + (tris_ext << 1);
        end
      end
      pfig_pkg::ST_FAN: begin
        if (slot_free) begin
          load             = 1'b1;
          fan_ctrl.advance = 1'b1;
          kind_d           = pfig_pkg::KIND_TRIANGLE;
          a_d              = fan_a;
          b_d              = fan_b;
          c_d              = fan_c;
          last_d           = fan_last;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= pfig_pkg::ST_IDLE;
      next_vertex_q <= '0;
      poly_tally_q  <= '0;
      index_tally_q <= '0;
      full_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      next_vertex_q <= next_vertex_d;
      poly_tally_q  <= poly_tally_d;
      index_tally_q <= index_tally_d;
      full_q        <= full_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q   <= action_i;
      count_q <= vertex_count_i;
    end
    if (load) begin
      kind_q    <= kind_d;
      a_q       <= a_d;
      b_q       <= b_d;
      c_q       <= c_d;
      polys_q   <= polys_d;
      verts_q   <= verts_d;
      idx_q     <= idx_d;
      indexed_q <= indexed_d;
      last_q    <= last_d;
    end
  end

  assign in_stall_o          = (state_q != pfig_pkg::ST_IDLE);
  assign out_valid_o         = out_valid_q;
  assign kind_o              = kind_q;
  assign corner_a_o          = a_q;
  assign corner_b_o          = b_q;
  assign corner_c_o          = c_q;
  assign polygons_in_batch_o = polys_q;
  assign vertices_in_batch_o = verts_q;
  assign indices_in_batch_o  = idx_q;
  assign use_indexed_o       = indexed_q;
  assign last_o              = last_q;

endmodule
